// ===== rtl/preemptive_priority_scheduler_assert.svh =====
// Assertion macros for the scheduler. They expect clk and arst_n in scope.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

	localparam int MAX_TASKS_DEF = 16;
	localparam int TIME_W        = 24;
	localparam int BURST_W       = 16;
	localparam int PRIO_W        = 8;
	localparam int SUM_W         = 28;
	localparam int TASK_IDX_W    = 4;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

	typedef logic [1:0] action_t;
	localparam action_t ACT_LOAD  = 2'd0;
	localparam action_t ACT_TICK  = 2'd1;
	localparam action_t ACT_CLEAR = 2'd2;

	// Input tdata, lowest bits first: arrival, burst, priority_req.
	typedef struct packed {
		logic [PRIO_W-1:0]  priority_req;
		logic [BURST_W-1:0] burst;
		logic [TIME_W-1:0]  arrival;
	} in_data_t;

	localparam int S_TDATA_W = $bits(in_data_t);

	// Output tdata, lowest bits first, padded with zeros to whole bytes.
	typedef struct packed {
		logic [5:0]            pad;
		logic                  error;
		logic [SUM_W-1:0]      total_response;
		logic [SUM_W-1:0]      total_waiting;
		logic [SUM_W-1:0]      total_turnaround;
		logic                  all_done;
		logic [TIME_W-1:0]     response;
		logic [TIME_W-1:0]     waiting;
		logic [TIME_W-1:0]     turnaround;
		logic [TIME_W-1:0]     completion_time;
		logic [TASK_IDX_W-1:0] task_index;
	} out_data_t;

	localparam int M_TDATA_W = $bits(out_data_t);

	typedef struct packed {
		logic finished;
		logic idle;
	} out_user_t;

	// One task table entry, held in the task RAM.
	typedef struct packed {
		logic [TIME_W-1:0]  first_run;
		logic               started;
		logic [BURST_W-1:0] remaining;
		logic [PRIO_W-1:0]  prio;
		logic [BURST_W-1:0] burst;
		logic [TIME_W-1:0]  arrival;
	} task_entry_t;

	localparam int ENTRY_W = $bits(task_entry_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_CALC1,
		ST_CALC2,
		ST_CALC3,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic scan_issue;
		logic calc1;
		logic calc2;
		logic calc3;
		logic commit;
	} pps_cmd_t;

	typedef struct packed {
		logic start_scan;
		logic scan_last;
		logic out_free;
	} pps_status_t;

	// Saturating accumulate; the top bit of the result flags saturation.
	function automatic logic [SUM_W:0] sat_add(input logic [SUM_W-1:0] acc,
			input logic [TIME_W-1:0] val);
		logic [SUM_W:0] s;
		s = {1'b0, acc} + (SUM_W+1)'(val);
		if (s[SUM_W]) begin
			return {1'b1, SUM_MAX};
		end
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/pps_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/pps_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pps_ctrl import pps_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire pps_status_t status,
	output pps_cmd_t         cmd
);

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = status.start_scan ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (status.scan_last) begin
					state_nx = ST_DRAIN;
				end
			end
			ST_DRAIN: state_nx = ST_CALC1;
			ST_CALC1: state_nx = ST_CALC2;
			ST_CALC2: state_nx = ST_CALC3;
			ST_CALC3: state_nx = ST_DONE;
			ST_DONE: begin
				if (status.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_SCAN:  cmd.scan_issue = 1'b1;
			ST_DRAIN: ;
			ST_CALC1: cmd.calc1 = 1'b1;
			ST_CALC2: cmd.calc2 = 1'b1;
			ST_CALC3: cmd.calc3 = 1'b1;
			ST_DONE:  cmd.commit = status.out_free;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/pps_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pps_dp import pps_pkg::*; #(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [S_TDATA_W-1:0]         s_axis_tdata,
	input  wire action_t                      s_axis_tuser,
	input  wire pps_cmd_t                     cmd,
	output pps_status_t                       status,
	output logic                              ram_we,
	output logic [$clog2(MAX_TASKS)-1:0]      ram_waddr,
	output task_entry_t                       ram_wdata,
	output logic [$clog2(MAX_TASKS)-1:0]      ram_raddr,
	input  wire task_entry_t                  ram_rdata,
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output logic [M_TDATA_W-1:0]              m_axis_tdata,
	output logic [1:0]                        m_axis_tuser
);

	localparam int IDX_W = $clog2(MAX_TASKS);
	localparam int CNT_W = $clog2(MAX_TASKS + 1);

	in_data_t in_d;
	assign in_d = s_axis_tdata;

	// Captured item.
	action_t            act_q;
	logic [TIME_W-1:0]  arr_q;
	logic [BURST_W-1:0] burst_q;
	logic [PRIO_W-1:0]  prio_q;

	// Scheduler state.
	logic [CNT_W-1:0]  loaded_cnt_q;
	logic [CNT_W-1:0]  done_cnt_q;
	logic [TIME_W-1:0] time_q;
	logic [SUM_W-1:0]  sum_tat_q;
	logic [SUM_W-1:0]  sum_wt_q;
	logic [SUM_W-1:0]  sum_rt_q;

	// Scan and selection.
	logic [IDX_W-1:0] scan_cnt_q;
	logic             rd_valid_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             pick_found_q;
	logic [IDX_W-1:0] pick_idx_q;
	task_entry_t      best_q;
	logic             eligible;

	// Completion arithmetic.
	logic [TIME_W-1:0]  ct_q;
	logic [TIME_W-1:0]  rt_q;
	logic [TIME_W-1:0]  tat_q;
	logic [TIME_W-1:0]  wt_q;
	logic [TIME_W-1:0]  first_eff_q;
	logic [BURST_W-1:0] rem_new_q;
	logic               fin_q;
	logic [TIME_W-1:0]  first_eff;

	// Output register.
	logic      m_valid_q;
	out_data_t m_data_q;
	out_user_t m_user_q;

	// Next-state values applied on commit.
	logic [CNT_W-1:0]  loaded_nx;
	logic [CNT_W-1:0]  done_nx;
	logic [TIME_W-1:0] time_nx;
	logic [SUM_W-1:0]  sum_tat_nx;
	logic [SUM_W-1:0]  sum_wt_nx;
	logic [SUM_W-1:0]  sum_rt_nx;
	logic [SUM_W:0]    add_tat;
	logic [SUM_W:0]    add_wt;
	logic [SUM_W:0]    add_rt;
	logic              err;
	logic              we_c;
	out_data_t         res_d;
	out_user_t         res_u;
	task_entry_t       load_entry;
	logic [BURST_W-1:0] burst_eff;

	assign status.start_scan = (s_axis_tuser == ACT_TICK) && (loaded_cnt_q != '0);
	assign status.scan_last  = CNT_W'(scan_cnt_q) == (loaded_cnt_q - CNT_W'(1));
	assign status.out_free   = !m_valid_q || m_axis_tready;

	assign ram_raddr = scan_cnt_q;

	assign eligible = rd_valid_s1 && (ram_rdata.arrival <= time_q) &&
		(ram_rdata.remaining != '0) && (!pick_found_q || (ram_rdata.prio < best_q.prio));

	assign first_eff = best_q.started ? best_q.first_run : time_q;

	assign burst_eff = (burst_q == '0) ? BURST_W'(1) : burst_q;

	always_comb begin
		load_entry           = '0;
		load_entry.arrival   = arr_q;
		load_entry.burst     = burst_eff;
		load_entry.prio      = prio_q;
		load_entry.remaining = burst_eff;
	end

	assign add_tat = sat_add(sum_tat_q, tat_q);
	assign add_wt  = sat_add(sum_wt_q, wt_q);
	assign add_rt  = sat_add(sum_rt_q, rt_q);

	always_comb begin
		loaded_nx  = loaded_cnt_q;
		done_nx    = done_cnt_q;
		time_nx    = time_q;
		sum_tat_nx = sum_tat_q;
		sum_wt_nx  = sum_wt_q;
		sum_rt_nx  = sum_rt_q;
		err        = 1'b0;
		we_c       = 1'b0;
		ram_waddr  = pick_idx_q;
		ram_wdata  = best_q;
		res_d      = '0;
		res_u      = '0;
		unique case (act_q)
			ACT_LOAD: begin
				if (loaded_cnt_q < CNT_W'(MAX_TASKS)) begin
					we_c             = 1'b1;
					ram_waddr        = loaded_cnt_q[IDX_W-1:0];
					ram_wdata        = load_entry;
					loaded_nx        = loaded_cnt_q + CNT_W'(1);
					res_d.task_index = TASK_IDX_W'(loaded_cnt_q);
				end else begin
					err = 1'b1;
				end
			end
			ACT_TICK: begin
				if (time_q == TIME_MAX) begin
					err = 1'b1;
				end else begin
					time_nx = time_q + TIME_W'(1);
				end
				if (pick_found_q) begin
					we_c                = 1'b1;
					ram_wdata.remaining = rem_new_q;
					ram_wdata.started   = 1'b1;
					ram_wdata.first_run = first_eff_q;
					res_d.task_index    = TASK_IDX_W'(pick_idx_q);
					if (fin_q) begin
						done_nx               = done_cnt_q + CNT_W'(1);
						res_u.finished        = 1'b1;
						res_d.completion_time = ct_q;
						res_d.turnaround      = tat_q;
						res_d.waiting         = wt_q;
						res_d.response        = rt_q;
						sum_tat_nx            = add_tat[SUM_W-1:0];
						sum_wt_nx             = add_wt[SUM_W-1:0];
						sum_rt_nx             = add_rt[SUM_W-1:0];
						err = err || add_tat[SUM_W] || add_wt[SUM_W] || add_rt[SUM_W];
					end
				end else begin
					res_u.idle = 1'b1;
				end
			end
			ACT_CLEAR: begin
				loaded_nx  = '0;
				done_nx    = '0;
				time_nx    = '0;
				sum_tat_nx = '0;
				sum_wt_nx  = '0;
				sum_rt_nx  = '0;
			end
			default: ;
		endcase
		res_d.all_done         = (done_nx == loaded_nx);
		res_d.total_turnaround = sum_tat_nx;
		res_d.total_waiting    = sum_wt_nx;
		res_d.total_response   = sum_rt_nx;
		res_d.error            = err;
	end

	assign ram_we = cmd.commit && we_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_cnt_q <= '0;
			done_cnt_q   <= '0;
			time_q       <= '0;
			sum_tat_q    <= '0;
			sum_wt_q     <= '0;
			sum_rt_q     <= '0;
			scan_cnt_q   <= '0;
			rd_valid_s1  <= 1'b0;
			pick_found_q <= 1'b0;
			fin_q        <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.scan_issue;
			if (cmd.capture) begin
				scan_cnt_q   <= '0;
				pick_found_q <= 1'b0;
				fin_q        <= 1'b0;
			end
			if (cmd.scan_issue) begin
				scan_cnt_q <= scan_cnt_q + IDX_W'(1);
			end
			if (eligible) begin
				pick_found_q <= 1'b1;
			end
			if (cmd.calc1) begin
				fin_q <= pick_found_q && (best_q.remaining == BURST_W'(1));
			end
			if (cmd.commit) begin
				loaded_cnt_q <= loaded_nx;
				done_cnt_q   <= done_nx;
				time_q       <= time_nx;
				sum_tat_q    <= sum_tat_nx;
				sum_wt_q     <= sum_wt_nx;
				sum_rt_q     <= sum_rt_nx;
				m_valid_q    <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q   <= s_axis_tuser;
			arr_q   <= in_d.arrival;
			burst_q <= in_d.burst;
			prio_q  <= in_d.priority_req;
		end
		if (cmd.scan_issue) begin
			rd_idx_s1 <= scan_cnt_q;
		end
		if (eligible) begin
			pick_idx_q <= rd_idx_s1;
			best_q     <= ram_rdata;
		end
		if (cmd.calc1) begin
			first_eff_q <= first_eff;
			rt_q        <= first_eff - best_q.arrival;
			ct_q        <= (time_q == TIME_MAX) ? time_q : time_q + TIME_W'(1);
			rem_new_q   <= best_q.remaining - BURST_W'(1);
		end
		if (cmd.calc2) begin
			tat_q <= ct_q - best_q.arrival;
		end
		if (cmd.calc3) begin
			// Waiting time can only go negative once time has saturated.
			wt_q <= (tat_q >= TIME_W'(best_q.burst)) ? tat_q - TIME_W'(best_q.burst) : '0;
		end
		if (cmd.commit) begin
			m_data_q <= res_d;
			m_user_q <= res_u;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire

// ===== rtl/preemptive_priority_scheduler.sv =====
// Channel   Direction  Signals                  Contents
// s_axis    in         tvalid tready tdata      one command: load, tick or clear
//                      tuser                    action code
// m_axis    out        tvalid tready tdata      one result per accepted command
//                      tuser                    idle and finished flags
//
// A load, a clear, an unused action code, or a tick with no task loaded passes through
// the transfer cycle and the commit cycle; its result is registered at the commit.
// A tick with N tasks loaded passes through the transfer cycle, N reads of the task
// RAM's single read port, a drain step, three arithmetic steps and the commit cycle;
// its result is registered at the commit.
// Reset clears the counters, time and totals; the task RAM holds no reset value and
// needs no clearing pass, as only loaded entries are ever read.
// The result register lets the next command be taken while a result waits; a command
// then holds in its commit cycle until the result register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "preemptive_priority_scheduler_assert.svh"

module preemptive_priority_scheduler import pps_pkg::*; #(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	// arrival [23:0], burst [39:24], priority_req [47:40]
	input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
	// action [1:0]
	input  wire logic [1:0]           s_axis_tuser,
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// task_index [3:0], completion_time [27:4], turnaround [51:28], waiting [75:52],
	// response [99:76], all_done [100], total_turnaround [128:101],
	// total_waiting [156:129], total_response [184:157], error [185], zeros [191:186]
	output logic [M_TDATA_W-1:0]      m_axis_tdata,
	// idle [0], finished [1]
	output logic [1:0]                m_axis_tuser
);

	localparam int IDX_W = $clog2(MAX_TASKS);

	pps_cmd_t         cmd;
	pps_status_t      status;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [IDX_W-1:0] ram_raddr;
	task_entry_t      ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;

	pps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	pps_dp #(
		.MAX_TASKS (MAX_TASKS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cmd           (cmd),
		.status        (status),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	pps_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_TASKS)
	) u_task_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// A committed step always shows up as a valid result in the next cycle.
	`PPS_ASSERT_NEXT(a_commit_shows, cmd.commit, m_axis_tvalid, "commit without result")

	// After a transfer in, the block is busy in the next cycle.
	`PPS_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready,
		"input taken twice in a row")

	// A completed task cannot also be an idle tick.
	`PPS_ASSERT_NOW(a_fin_not_idle, m_axis_tvalid && m_axis_tuser[1], !m_axis_tuser[0],
		"finished and idle together")

	// First run is never later than completion, so turnaround covers response.
	`PPS_ASSERT_NOW(a_tat_ge_resp, m_axis_tvalid && m_axis_tuser[1],
		m_axis_tdata[51:28] >= m_axis_tdata[99:76], "turnaround below response")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import pps_pkg::*;

	localparam int TASKS          = MAX_TASKS_DEF;
	localparam int RANDOM_ITEMS   = 1600;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 40;
	localparam action_t ACT_UNDEFINED = 2'd3;

	typedef struct {
		out_data_t data;
		out_user_t flags;
	} sched_result_t;

	class sched_scoreboard;
		logic [TIME_W-1:0]  arr_tab [TASKS];
		logic [BURST_W-1:0] burst_tab [TASKS];
		logic [PRIO_W-1:0]  prio_tab [TASKS];
		logic [BURST_W-1:0] rem_tab [TASKS];
		logic               started_tab [TASKS];
		logic [TIME_W-1:0]  first_tab [TASKS];
		int                 loaded_n;
		int                 done_n;
		logic [TIME_W-1:0]  clock_now;
		logic [SUM_W-1:0]   sum_tat;
		logic [SUM_W-1:0]   sum_wait;
		logic [SUM_W-1:0]   sum_resp;
		sched_result_t      expected_q [$];
		int                 mismatches;

		function new();
			mismatches = 0;
			clear_state();
		endfunction

		function void clear_state();
			loaded_n  = 0;
			done_n    = 0;
			clock_now = '0;
			sum_tat   = '0;
			sum_wait  = '0;
			sum_resp  = '0;
			for (int i = 0; i < TASKS; i++) begin
				started_tab[i] = 1'b0;
			end
		endfunction

		function bit settled();
			return done_n == loaded_n;
		endfunction

		// The top bit of the result says that the total hit its ceiling.
		function logic [SUM_W:0] saturating_sum(input logic [SUM_W-1:0] acc,
				input logic [TIME_W-1:0] val);
			logic [SUM_W:0] s;
			s = {1'b0, acc} + (SUM_W+1)'(val);
			if (s > (SUM_W+1)'(SUM_MAX)) begin
				s = {1'b1, SUM_MAX};
			end
			return s;
		endfunction

		function void note_command(input action_t act, input in_data_t cmd);
			sched_result_t      r;
			logic [BURST_W-1:0] blen;
			logic [PRIO_W-1:0]  best;
			logic [TIME_W-1:0]  t0;
			logic [TIME_W-1:0]  tat;
			logic [TIME_W-1:0]  wt;
			logic [TIME_W-1:0]  rt;
			logic [SUM_W:0]     s;
			int                 pick;
			logic               err;
			r.data  = '0;
			r.flags = '0;
			err     = 1'b0;
			case (act)
			ACT_LOAD: begin
				if (loaded_n < TASKS) begin
					blen = (cmd.burst == '0) ? BURST_W'(1) : cmd.burst;
					arr_tab[loaded_n]     = cmd.arrival;
					burst_tab[loaded_n]   = blen;
					prio_tab[loaded_n]    = cmd.priority_req;
					rem_tab[loaded_n]     = blen;
					started_tab[loaded_n] = 1'b0;
					first_tab[loaded_n]   = '0;
					r.data.task_index     = TASK_IDX_W'(loaded_n);
					loaded_n++;
				end else begin
					err = 1'b1;
				end
			end
			ACT_TICK: begin
				pick = -1;
				best = '0;
				t0   = clock_now;
				for (int i = 0; i < loaded_n; i++) begin
					if (arr_tab[i] <= t0 && rem_tab[i] != '0 &&
							(pick < 0 || prio_tab[i] < best)) begin
						best = prio_tab[i];
						pick = i;
					end
				end
				if (t0 == TIME_MAX) begin
					err = 1'b1;
				end else begin
					clock_now = t0 + 1'b1;
				end
				if (pick < 0) begin
					r.flags.idle = 1'b1;
				end else begin
					r.data.task_index = TASK_IDX_W'(pick);
					if (!started_tab[pick]) begin
						started_tab[pick] = 1'b1;
						first_tab[pick]   = t0;
					end
					rem_tab[pick] = rem_tab[pick] - 1'b1;
					if (rem_tab[pick] == '0) begin
						done_n++;
						tat = clock_now - arr_tab[pick];
						wt  = (tat >= TIME_W'(burst_tab[pick])) ?
							tat - TIME_W'(burst_tab[pick]) : '0;
						rt  = first_tab[pick] - arr_tab[pick];
						r.flags.finished       = 1'b1;
						r.data.completion_time = clock_now;
						r.data.turnaround      = tat;
						r.data.waiting         = wt;
						r.data.response        = rt;
						s        = saturating_sum(sum_tat, tat);
						sum_tat  = s[SUM_W-1:0];
						err      = err | s[SUM_W];
						s        = saturating_sum(sum_wait, wt);
						sum_wait = s[SUM_W-1:0];
						err      = err | s[SUM_W];
						s        = saturating_sum(sum_resp, rt);
						sum_resp = s[SUM_W-1:0];
						err      = err | s[SUM_W];
					end
				end
			end
			ACT_CLEAR: begin
				clear_state();
			end
			default: begin
			end
			endcase
			r.data.all_done         = (done_n == loaded_n);
			r.data.total_turnaround = sum_tat;
			r.data.total_waiting    = sum_wait;
			r.data.total_response   = sum_resp;
			r.data.error            = err;
			expected_q.push_back(r);
		endfunction

		function void check_field(input string name, input logic [31:0] want,
				input logic [31:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
				end
			end
		endfunction

		function void check_result(input out_data_t got, input out_user_t got_flags);
			sched_result_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result transfer with no command outstanding", $realtime);
				end
				return;
			end
			want = expected_q.pop_front();
			check_field("task_index", want.data.task_index, got.task_index);
			check_field("idle", want.flags.idle, got_flags.idle);
			check_field("finished", want.flags.finished, got_flags.finished);
			check_field("completion_time", want.data.completion_time, got.completion_time);
			check_field("turnaround", want.data.turnaround, got.turnaround);
			check_field("waiting", want.data.waiting, got.waiting);
			check_field("response", want.data.response, got.response);
			check_field("all_done", want.data.all_done, got.all_done);
			check_field("total_turnaround", want.data.total_turnaround, got.total_turnaround);
			check_field("total_waiting", want.data.total_waiting, got.total_waiting);
			check_field("total_response", want.data.total_response, got.total_response);
			check_field("error", want.data.error, got.error);
			check_field("pad", want.data.pad, got.pad);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [1:0]           s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [1:0]           m_axis_tuser;

	sched_scoreboard sb = new();
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int counted_items = 0;
	int stall_cycles = 0;

	preemptive_priority_scheduler uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_result(out_data_t'(m_axis_tdata), out_user_t'(m_axis_tuser));
		end
	end

	// Ends the run if neither side moves a transfer for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer, with
	// tvalid still high so that a following command goes out without a gap.
	task automatic send_cmd(input action_t act, input in_data_t cmd);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= cmd;
		s_axis_tuser  <= act;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		sb.note_command(act, cmd);
		if (act != ACT_UNDEFINED) begin
			counted_items++;
		end
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	function automatic in_data_t random_payload();
		in_data_t p;
		p.arrival      = TIME_W'($urandom);
		p.burst        = BURST_W'($urandom);
		p.priority_req = PRIO_W'($urandom);
		return p;
	endfunction

	// Mostly near-term arrivals and short bursts so that tasks complete; now and then
	// a zero burst, a huge burst, an arrival at time zero or one far in the future.
	function automatic in_data_t random_task(input logic [TIME_W-1:0] base);
		in_data_t    t;
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 80) begin
			t.arrival = base + TIME_W'($urandom_range(0, 12));
		end else if (sel < 90) begin
			t.arrival = '0;
		end else begin
			t.arrival = TIME_W'($urandom);
		end
		sel = $urandom_range(0, 99);
		if (sel < 88) begin
			t.burst = BURST_W'($urandom_range(1, 6));
		end else if (sel < 94) begin
			t.burst = '0;
		end else begin
			t.burst = BURST_W'($urandom);
		end
		if ($urandom_range(0, 1) == 0) begin
			t.priority_req = PRIO_W'($urandom_range(0, 3));
		end else begin
			t.priority_req = PRIO_W'($urandom);
		end
		return t;
	endfunction

	task automatic run_sequence();
		int          n_ticks;
		int unsigned sel;
		if ((sb.loaded_n >= 12 && $urandom_range(0, 3) != 0) ||
				$urandom_range(0, 9) == 0) begin
			send_cmd(ACT_CLEAR, random_payload());
		end
		repeat ($urandom_range(1, 5)) begin
			send_cmd(ACT_LOAD, random_task(sb.clock_now));
		end
		n_ticks = 0;
		while (!sb.settled() && n_ticks < 40) begin
			sel = $urandom_range(0, 99);
			if (sel < 3) begin
				send_cmd(ACT_UNDEFINED, random_payload());
			end else if (sel < 7) begin
				send_cmd(ACT_LOAD, random_task(sb.clock_now));
			end else begin
				send_cmd(ACT_TICK, random_payload());
				n_ticks++;
			end
		end
		repeat ($urandom_range(0, 2)) begin
			send_cmd(ACT_TICK, random_payload());
		end
	endtask

	initial begin
		in_data_t cmd;
		int       phase;
		int       new_phase;
		int       random_base;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: an empty tick, the field extremes, a priority tie, a full table.
		send_cmd(ACT_TICK, random_payload());
		cmd.arrival      = '0;
		cmd.burst        = '0;
		cmd.priority_req = '1;
		send_cmd(ACT_LOAD, cmd);
		cmd.burst        = BURST_W'(3);
		cmd.priority_req = '0;
		send_cmd(ACT_LOAD, cmd);
		cmd.arrival      = TIME_W'(1);
		cmd.burst        = BURST_W'(2);
		send_cmd(ACT_LOAD, cmd);
		cmd.arrival      = TIME_MAX;
		cmd.burst        = '1;
		cmd.priority_req = PRIO_W'(128);
		send_cmd(ACT_LOAD, cmd);
		for (int i = 4; i < TASKS; i++) begin
			cmd.arrival      = TIME_W'($urandom_range(0, 5));
			cmd.burst        = BURST_W'($urandom_range(1, 4));
			cmd.priority_req = PRIO_W'($urandom_range(1, 254));
			send_cmd(ACT_LOAD, cmd);
		end
		send_cmd(ACT_LOAD, random_payload());
		repeat (4) begin
			send_cmd(ACT_TICK, random_payload());
		end
		send_cmd(ACT_UNDEFINED, random_payload());
		send_cmd(ACT_CLEAR, random_payload());

		random_base = counted_items;
		phase = -1;
		while (counted_items - random_base < RANDOM_ITEMS) begin
			new_phase = (counted_items - random_base) * 4 / RANDOM_ITEMS;
			if (new_phase != phase) begin
				// Hold the sender back until every outstanding result has come out.
				wait_drained();
				phase = new_phase;
				case (phase)
				0: begin
					sender_idle_pct = 0;
					recv_stall_pct  = 0;
				end
				1: begin
					sender_idle_pct = 71;
					recv_stall_pct  = 0;
				end
				2: begin
					sender_idle_pct = 0;
					recv_stall_pct  = 71;
				end
				default: begin
					sender_idle_pct = 20;
					recv_stall_pct  = 20;
				end
				endcase
			end
			run_sequence();
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pps_pkg.sv
rtl/pps_ram.sv
rtl/pps_ctrl.sv
rtl/pps_dp.sv
rtl/preemptive_priority_scheduler.sv
tb/sv/tb.sv
